// ===== sv/sldlp_pkg.sv =====
// Package for the station level solver: shared types, constants and states.
`timescale 1ns / 1ps
package sldlp_pkg;

    localparam int MAX_STATIONS_DEF = 1024;
    localparam int MAX_TRAINS_DEF   = 1024;
    localparam int MAX_EDGES_DEF    = 1048576;

    localparam int SCW        = 11;    // station and level field width
    localparam int LEVEL_CAP  = 2047;
    localparam int CMDQ_DEPTH = 4;

    typedef struct packed {
        logic             mode;
        logic [SCW-1:0]   station;
        logic             last_stop;
    } in_t;

    typedef struct packed {
        logic [SCW-1:0]   max_level;
        logic             edges_overflowed;
        logic             cycle_found;
    } res_t;

    // command handed from the front part to the back part
    typedef struct packed {
        logic             solve_req;
        logic             mark_ok;
        logic [SCW-1:0]   station;
        logic             last_stop;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_SET,
        ST_SCAN_RD,
        ST_SCAN_WR,
        ST_TRAIN_END,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_POP,
        ST_POP_WAIT,
        ST_NODE,
        ST_EDGE_RD,
        ST_EDGE_UPD,
        ST_MAX_RD,
        ST_MAX_ACC,
        ST_DONE
    } back_state_t;

endpackage

// ===== sv/station_level_dag_longest_path.sv =====
// Top level of the station level solver: config register, front and back parts.
`timescale 1ns / 1ps
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  input    | push / full          | item   (mode, station, last_stop)
//  result   | empty / pop          | result (max_level, edges_overflowed,
//           |                      |         cycle_found)
//  config   | cfg_we               | cfg_wdata (station_count)
//
//  The last stop of a train adds a scan over the span of its marked stations.
//  A solve runs an init pass over the nodes, a walk over each dequeued node
//  and its edges, a check that finds the order queue empty, a max scan over
//  the real stations, and then posts the result. The node and edge RAMs each
//  have one read port.
//  After reset a clearing pass runs over all MAX_STATIONS + MAX_TRAINS + 1
//  node entries; full stays high until it ends. A four-entry command queue
//  lets the front take items while the back works; the back waits on a result
//  not yet popped.
//
module station_level_dag_longest_path
    import sldlp_pkg::*;
#(
    parameter int MAX_STATIONS = MAX_STATIONS_DEF,
    parameter int MAX_TRAINS   = MAX_TRAINS_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  in_t            item,
    output logic           empty,
    input  logic           pop,
    output res_t           result,
    input  logic           cfg_we,
    input  logic [SCW-1:0] cfg_wdata
);

    logic [SCW-1:0] sc_reg, sc_next;
    logic           cmd_valid;
    cmd_t           cmd;
    logic           cmd_pop;
    logic           clearing;

    // station count saturates at the build-time station limit
    always_comb
    begin
        sc_next = sc_reg;
        if (cfg_we)
        begin
            sc_next = (32'(cfg_wdata) > MAX_STATIONS) ? SCW'(MAX_STATIONS) : cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg <= SCW'(1);
        end
        else
        begin
            sc_reg <= sc_next;
        end
    end

    sldlp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .station_count (sc_reg),
        .clearing      (clearing),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    sldlp_back #(
        .MAX_STATIONS (MAX_STATIONS),
        .MAX_TRAINS   (MAX_TRAINS),
        .MAX_EDGES    (MAX_EDGES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .station_count (sc_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .clearing      (clearing),
        .empty         (empty),
        .pop           (pop),
        .result        (result)
    );

endmodule

// ===== sv/sldlp_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module sldlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/sldlp_front.sv =====
// Front part: accepts items, range-checks stops and queues commands.
`timescale 1ns / 1ps
module sldlp_front
    import sldlp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  in_t            item,
    input  logic [SCW-1:0] station_count,
    input  logic           clearing,
    output logic           cmd_valid,
    output cmd_t           cmd,
    input  logic           cmd_pop
);

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    cmd_t          q_reg [CMDQ_DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          accept;
    logic          take;
    cmd_t          new_cmd;

    assign full      = (cnt_reg == CW'(CMDQ_DEPTH)) || clearing;
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != '0);
    assign take      = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rptr_reg];

    always_comb
    begin
        new_cmd.solve_req = item.mode;
        new_cmd.mark_ok   = (item.station != '0) && (item.station <= station_count);
        new_cmd.station   = item.station;
        new_cmd.last_stop = item.last_stop;
    end

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (accept)
        begin
            wptr_next = (wptr_reg == PW'(CMDQ_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (take)
        begin
            rptr_next = (rptr_reg == PW'(CMDQ_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CW'(accept) - CW'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wptr_reg] <= new_cmd;
        end
    end

endmodule

// ===== sv/sldlp_back.sv =====
// Back part: builds the edge lists per train and runs the level solve.
`timescale 1ns / 1ps
module sldlp_back
    import sldlp_pkg::*;
#(
    parameter int MAX_STATIONS = MAX_STATIONS_DEF,
    parameter int MAX_TRAINS   = MAX_TRAINS_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [SCW-1:0] station_count,
    input  logic           cmd_valid,
    input  cmd_t           cmd,
    output logic           cmd_pop,
    output logic           clearing,
    output logic           empty,
    input  logic           pop,
    output res_t           result
);

    localparam int NS  = MAX_STATIONS + MAX_TRAINS + 1;
    localparam int NW  = $clog2(NS);
    localparam int SW  = $clog2(MAX_STATIONS + 1);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int TW  = $clog2(MAX_TRAINS + 1);
    localparam int EDW = NW + EW + 1;
    localparam logic [EW-1:0] NO_EDGE = EW'(MAX_EDGES);

    back_state_t   state_reg, state_next;
    logic [NW-1:0] clr_reg, clr_next;
    logic [SCW-1:0] span_lo_reg, span_lo_next;
    logic [SCW-1:0] span_hi_reg, span_hi_next;
    logic [TW-1:0] tcount_reg, tcount_next;
    logic [EW-1:0] ecount_reg, ecount_next;
    logic          ovf_reg, ovf_next;
    logic [SCW-1:0] j_reg, j_next;
    logic          drop_reg, drop_next;
    logic [EW-1:0] vhead_reg, vhead_next;
    logic [NW-1:0] vdeg_reg, vdeg_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [NW-1:0] qhead_reg, qhead_next;
    logic [NW-1:0] qtail_reg, qtail_next;
    logic [NW-1:0] lt_reg, lt_next;
    logic [EW-1:0] e_reg, e_next;
    logic [NW-1:0] tj_reg, tj_next;
    logic          w_reg, w_next;
    logic [NW-1:0] best_reg, best_next;
    logic          rv_reg, rv_next;
    res_t          res_reg, res_next;

    // RAM ports
    logic           mk_we, mk_wdata, mk_rdata;
    logic [SW-1:0]  mk_waddr, mk_raddr;
    logic           hd_we;
    logic [NW-1:0]  hd_waddr, hd_raddr;
    logic [EW-1:0]  hd_wdata, hd_rdata;
    logic           dg_we;
    logic [NW-1:0]  dg_waddr, dg_raddr, dg_wdata, dg_rdata;
    logic           ed_we;
    logic [EAW-1:0] ed_waddr, ed_raddr;
    logic [EDW-1:0] ed_wdata, ed_rdata;
    logic           wd_we;
    logic [NW-1:0]  wd_waddr, wd_raddr, wd_wdata, wd_rdata;
    logic           lv_we;
    logic [NW-1:0]  lv_waddr, lv_raddr, lv_wdata, lv_rdata;
    logic           qu_we;
    logic [NW-1:0]  qu_waddr, qu_raddr, qu_wdata, qu_rdata;

    // shared terms
    logic [SCW-1:0] scan_lo;
    logic           drop_now;
    logic [NW-1:0]  vnode;
    logic [NW-1:0]  last_node;
    logic [NW-1:0]  sc_n;
    logic           in_range;
    logic           emit;
    logic           room;
    logic [NW-1:0]  ed_target;
    logic [EW-1:0]  ed_link;
    logic           ed_w;
    logic [NW-1:0]  cand;
    logic [31:0]    best_wide;

    assign scan_lo   = (span_lo_reg == '0) ? SCW'(1) : span_lo_reg;
    assign drop_now  = (32'(tcount_reg) >= MAX_TRAINS);
    assign vnode     = NW'(MAX_STATIONS + 1) + NW'(tcount_reg);
    assign last_node = NW'(MAX_STATIONS) + NW'(tcount_reg);
    assign sc_n      = NW'(station_count);
    assign in_range  = (j_reg <= station_count);
    assign emit      = in_range && !drop_reg;
    assign room      = (ecount_reg != NO_EDGE);
    assign ed_target = ed_rdata[EDW-1 -: NW];
    assign ed_link   = ed_rdata[EW:1];
    assign ed_w      = ed_rdata[0];
    assign cand      = lt_reg + NW'(w_reg);
    assign best_wide = 32'(best_reg);

    assign clearing = (state_reg == ST_CLEAR);
    assign empty    = !rv_reg;
    assign result   = res_reg;

    sldlp_ram #(.WIDTH(1), .DEPTH(MAX_STATIONS + 1)) u_marks (
        .clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
        .raddr(mk_raddr), .rdata(mk_rdata));
    sldlp_ram #(.WIDTH(EW), .DEPTH(NS)) u_head (
        .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .raddr(hd_raddr), .rdata(hd_rdata));
    sldlp_ram #(.WIDTH(NW), .DEPTH(NS)) u_indeg (
        .clk(clk), .we(dg_we), .waddr(dg_waddr), .wdata(dg_wdata),
        .raddr(dg_raddr), .rdata(dg_rdata));
    sldlp_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edges (
        .clk(clk), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
        .raddr(ed_raddr), .rdata(ed_rdata));
    sldlp_ram #(.WIDTH(NW), .DEPTH(NS)) u_wdeg (
        .clk(clk), .we(wd_we), .waddr(wd_waddr), .wdata(wd_wdata),
        .raddr(wd_raddr), .rdata(wd_rdata));
    sldlp_ram #(.WIDTH(NW), .DEPTH(NS)) u_level (
        .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
        .raddr(lv_raddr), .rdata(lv_rdata));
    sldlp_ram #(.WIDTH(NW), .DEPTH(NS)) u_queue (
        .clk(clk), .we(qu_we), .waddr(qu_waddr), .wdata(qu_wdata),
        .raddr(qu_raddr), .rdata(qu_rdata));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == NW'(NS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.solve_req)
                        state_next = ST_INIT_RD;
                    else if (cmd.last_stop)
                        state_next = ST_SCAN_SET;
                end
            end
            ST_SCAN_SET:
            begin
                state_next = (scan_lo > span_hi_reg) ? ST_TRAIN_END : ST_SCAN_RD;
            end
            ST_SCAN_RD:   state_next = ST_SCAN_WR;
            ST_SCAN_WR:
            begin
                state_next = (j_reg == span_hi_reg) ? ST_TRAIN_END : ST_SCAN_RD;
            end
            ST_TRAIN_END: state_next = ST_IDLE;
            ST_INIT_RD:   state_next = ST_INIT_WR;
            ST_INIT_WR:
            begin
                state_next = (idx_reg == last_node) ? ST_POP : ST_INIT_RD;
            end
            ST_POP:
            begin
                if (qhead_reg == qtail_reg)
                    state_next = (sc_n == '0) ? ST_DONE : ST_MAX_RD;
                else
                    state_next = ST_POP_WAIT;
            end
            ST_POP_WAIT:  state_next = ST_NODE;
            ST_NODE:
            begin
                state_next = (hd_rdata == NO_EDGE) ? ST_POP : ST_EDGE_RD;
            end
            ST_EDGE_RD:   state_next = ST_EDGE_UPD;
            ST_EDGE_UPD:
            begin
                state_next = (e_reg == NO_EDGE) ? ST_POP : ST_EDGE_RD;
            end
            ST_MAX_RD:    state_next = ST_MAX_ACC;
            ST_MAX_ACC:
            begin
                state_next = (idx_reg == sc_n) ? ST_DONE : ST_MAX_RD;
            end
            ST_DONE:
            begin
                if (!rv_reg)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // memory ports and command pop
    always_comb
    begin
        cmd_pop  = 1'b0;
        mk_we    = 1'b0;
        mk_waddr = SW'(j_reg);
        mk_wdata = 1'b0;
        mk_raddr = SW'(j_reg);
        hd_we    = 1'b0;
        hd_waddr = NW'(j_reg);
        hd_wdata = ecount_reg;
        hd_raddr = NW'(j_reg);
        dg_we    = 1'b0;
        dg_waddr = NW'(j_reg);
        dg_wdata = dg_rdata + 1'b1;
        dg_raddr = NW'(j_reg);
        ed_we    = 1'b0;
        ed_waddr = ecount_reg[EAW-1:0];
        ed_wdata = mk_rdata ? {NW'(j_reg), vhead_reg, 1'b1} : {vnode, hd_rdata, 1'b0};
        ed_raddr = e_reg[EAW-1:0];
        wd_we    = 1'b0;
        wd_waddr = idx_reg;
        wd_wdata = dg_rdata;
        wd_raddr = ed_target;
        lv_we    = 1'b0;
        lv_waddr = idx_reg;
        lv_wdata = NW'(1);
        lv_raddr = qu_rdata;
        qu_we    = 1'b0;
        qu_waddr = qtail_reg;
        qu_wdata = idx_reg;
        qu_raddr = qhead_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mk_we    = (32'(clr_reg) <= MAX_STATIONS);
                mk_waddr = SW'(clr_reg);
                hd_we    = 1'b1;
                hd_waddr = clr_reg;
                hd_wdata = NO_EDGE;
                dg_we    = 1'b1;
                dg_waddr = clr_reg;
                dg_wdata = '0;
            end
            ST_IDLE:
            begin
                cmd_pop  = cmd_valid;
                mk_we    = cmd_valid && !cmd.solve_req && cmd.mark_ok;
                mk_waddr = SW'(cmd.station);
                mk_wdata = 1'b1;
            end
            ST_SCAN_WR:
            begin
                mk_we = 1'b1;
                ed_we = emit && room;
                hd_we = emit && room && !mk_rdata;
                dg_we = emit && room && mk_rdata;
            end
            ST_TRAIN_END:
            begin
                hd_we    = !drop_reg;
                hd_waddr = vnode;
                hd_wdata = vhead_reg;
                dg_we    = !drop_reg;
                dg_waddr = vnode;
                dg_wdata = vdeg_reg;
            end
            ST_INIT_RD:
            begin
                dg_raddr = idx_reg;
            end
            ST_INIT_WR:
            begin
                wd_we = 1'b1;
                lv_we = 1'b1;
                qu_we = (dg_rdata == '0);
            end
            ST_POP_WAIT:
            begin
                hd_raddr = qu_rdata;
            end
            ST_NODE:
            begin
                ed_raddr = hd_rdata[EAW-1:0];
            end
            ST_EDGE_RD:
            begin
                lv_raddr = ed_target;
            end
            ST_EDGE_UPD:
            begin
                lv_we    = (cand > lv_rdata);
                lv_waddr = tj_reg;
                lv_wdata = cand;
                wd_we    = (wd_rdata != '0);
                wd_waddr = tj_reg;
                wd_wdata = wd_rdata - 1'b1;
                qu_we    = (wd_rdata == NW'(1));
                qu_wdata = tj_reg;
            end
            ST_MAX_RD:
            begin
                lv_raddr = idx_reg;
            end
            default:
            begin
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        clr_next     = clr_reg;
        span_lo_next = span_lo_reg;
        span_hi_next = span_hi_reg;
        tcount_next  = tcount_reg;
        ecount_next  = ecount_reg;
        ovf_next     = ovf_reg;
        j_next       = j_reg;
        drop_next    = drop_reg;
        vhead_next   = vhead_reg;
        vdeg_next    = vdeg_reg;
        idx_next     = idx_reg;
        qhead_next   = qhead_reg;
        qtail_next   = qtail_reg;
        lt_next      = lt_reg;
        e_next       = e_reg;
        tj_next      = tj_reg;
        w_next       = w_reg;
        best_next    = best_reg;
        rv_next      = rv_reg && !pop;
        res_next     = res_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (cmd_valid && cmd.solve_req)
                begin
                    idx_next   = NW'(1);
                    qhead_next = '0;
                    qtail_next = '0;
                end
                else if (cmd_valid && cmd.mark_ok)
                begin
                    if (cmd.station < span_lo_reg)
                        span_lo_next = cmd.station;
                    if (cmd.station > span_hi_reg)
                        span_hi_next = cmd.station;
                end
            end
            ST_SCAN_SET:
            begin
                j_next     = scan_lo;
                drop_next  = drop_now;
                vhead_next = NO_EDGE;
                vdeg_next  = '0;
            end
            ST_SCAN_WR:
            begin
                j_next = j_reg + 1'b1;
                if (emit)
                begin
                    if (!room)
                        ovf_next = 1'b1;
                    else
                    begin
                        ecount_next = ecount_reg + 1'b1;
                        if (mk_rdata)
                            vhead_next = ecount_reg;
                        else
                            vdeg_next = vdeg_reg + 1'b1;
                    end
                end
            end
            ST_TRAIN_END:
            begin
                if (drop_reg)
                    ovf_next = 1'b1;
                else
                    tcount_next = tcount_reg + 1'b1;
                span_lo_next = station_count;
                span_hi_next = SCW'(1);
            end
            ST_INIT_WR:
            begin
                idx_next = idx_reg + 1'b1;
                if (dg_rdata == '0)
                    qtail_next = qtail_reg + 1'b1;
            end
            ST_POP:
            begin
                idx_next  = NW'(1);
                best_next = '0;
                if (qhead_reg != qtail_reg)
                    qhead_next = qhead_reg + 1'b1;
            end
            ST_NODE:
            begin
                lt_next = lv_rdata;
            end
            ST_EDGE_RD:
            begin
                tj_next = ed_target;
                w_next  = ed_w;
                e_next  = ed_link;
            end
            ST_EDGE_UPD:
            begin
                if (wd_rdata == NW'(1))
                    qtail_next = qtail_reg + 1'b1;
            end
            ST_MAX_ACC:
            begin
                idx_next = idx_reg + 1'b1;
                if (lv_rdata > best_reg)
                    best_next = lv_rdata;
            end
            ST_DONE:
            begin
                if (!rv_reg)
                begin
                    rv_next                   = 1'b1;
                    res_next.max_level        = (best_wide > 32'(LEVEL_CAP)) ?
                                                SCW'(LEVEL_CAP) : SCW'(best_reg);
                    res_next.edges_overflowed = ovf_reg;
                    res_next.cycle_found      = (qtail_reg < last_node);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            span_lo_reg <= SCW'(1);
            span_hi_reg <= SCW'(1);
            tcount_reg  <= '0;
            ecount_reg  <= '0;
            ovf_reg     <= 1'b0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            span_lo_reg <= span_lo_next;
            span_hi_reg <= span_hi_next;
            tcount_reg  <= tcount_next;
            ecount_reg  <= ecount_next;
            ovf_reg     <= ovf_next;
            rv_reg      <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        drop_reg  <= drop_next;
        vhead_reg <= vhead_next;
        vdeg_reg  <= vdeg_next;
        idx_reg   <= idx_next;
        qhead_reg <= qhead_next;
        qtail_reg <= qtail_next;
        lt_reg    <= lt_next;
        e_reg     <= e_next;
        tj_reg    <= tj_next;
        w_reg     <= w_next;
        best_reg  <= best_next;
        res_reg   <= res_next;
    end

endmodule
